// ===== rtl/bpa_pkg.sv =====
// bpa_pkg: shared types and constants of the bump page allocator
// depends on nothing; imported by bump_page_allocator_top and its testbench
`default_nettype none

package bpa_pkg;

	// default sizing
	localparam int MAX_RANGES_DEF = 16;
	localparam int PAGE_SHIFT_DEF = 12;

	// fixed field widths
	localparam int ADDR_W   = 64;
	localparam int TYPE_W   = 32;
	localparam int FREE_W   = 56;
	localparam int RUSED_W  = 5;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 64;

	// operation codes
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_ALLOC = 2'd2;

	// status codes
	localparam logic [1:0] STS_DONE    = 2'd0;
	localparam logic [1:0] STS_SKIPPED = 2'd1;
	localparam logic [1:0] STS_FULL    = 2'd2;
	localparam logic [1:0] STS_NO_PAGE = 2'd3;

	// register select (address bit 3)
	localparam logic REG_MIN_ADDRESS = 1'b0;
	localparam logic REG_USABLE_TYPE = 1'b1;

	// register reset values
	localparam logic [ADDR_W-1:0] MIN_ADDRESS_RST = 64'h0000_0000_0010_0000;
	localparam logic [TYPE_W-1:0] USABLE_TYPE_RST = 32'd1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_END,
		ST_LD_ALIGN,
		ST_LD_CHECK,
		ST_LD_SUM,
		ST_A_ADDR,
		ST_A_CHECK,
		ST_A_DEC,
		ST_DONE
	} bpa_state_t;

endpackage

`default_nettype wire

// ===== rtl/bpa_ram.sv =====
// bpa_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
`default_nettype none

module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire                                     clk,
	input  wire                                     we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                         wdata,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/bump_page_allocator_top.sv =====
// bump_page_allocator_top: page allocator over memory-map ranges
// depends on bpa_pkg and bpa_ram (range table of next-free/limit pairs)
// clear, unknown op and unusable entry go straight to the result; load passes the end, align,
// check and sum states as the entry allows; alloc skips exhausted ranges from the active one
// one item at a time: ready only while idle; all sums go through the shared 64-bit adder,
// and alloc reads the range table one range at a time through its registered read port
// reset: table empty, free count zero, registers at their reset values; no clearing pass
`default_nettype none

module bump_page_allocator_top #(
	parameter int MAX_RANGES = bpa_pkg::MAX_RANGES_DEF,
	parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// item channel
	input  wire                            item_valid,
	output logic                           item_ready,
	input  wire [1:0]                      op,
	input  wire [bpa_pkg::ADDR_W-1:0]      entry_base,
	input  wire [bpa_pkg::ADDR_W-1:0]      entry_length,
	input  wire [bpa_pkg::TYPE_W-1:0]      entry_type,
	// result channel
	output logic                           result_valid,
	input  wire                            result_ready,
	output logic [bpa_pkg::ADDR_W-1:0]     page_addr,
	output logic [1:0]                     status,
	output logic [bpa_pkg::FREE_W-1:0]     free_pages,
	output logic [bpa_pkg::RUSED_W-1:0]    ranges_used,
	// configuration port
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [bpa_pkg::PADDR_W-1:0]     paddr,
	input  wire [bpa_pkg::PDATA_W-1:0]     pwdata,
	output logic [bpa_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);

	import bpa_pkg::*;

	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int RW = 2 * ADDR_W;
	localparam logic [ADDR_W-1:0] PG_SIZE = ADDR_W'(64'd1 << PAGE_SHIFT);
	localparam logic [ADDR_W-1:0] PG_MASK = PG_SIZE - ADDR_W'(1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

	bpa_state_t state_q, state_d;

	// configuration registers
	logic [ADDR_W-1:0] min_address_q;
	logic [TYPE_W-1:0] usable_type_q;

	// control state
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     active_q;
	logic [CW-1:0]     idx_q;
	logic [ADDR_W-1:0] sum_q;
	logic              result_valid_q;

	// working payload
	logic [ADDR_W-1:0] base_q, len_q, start_q, end_q, pages_q, page_q;
	logic [1:0]        status_q;
	logic              wrap_q;
	logic [ADDR_W-1:0] res_page_q;
	logic [1:0]        res_status_q;
	logic [FREE_W-1:0] res_free_q;
	logic [RUSED_W-1:0] res_used_q;

	// shared adder
	logic [ADDR_W-1:0] add_a, add_b;
	logic              add_cin;
	logic [ADDR_W:0]   add_res;

	// range table
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata;
	logic [RW-1:0] ram_rdata;
	logic [ADDR_W-1:0] rd_next, rd_limit;

	logic item_xfer, cfg_wr, done_fire, fits, nonempty;

	assign item_ready = (state_q == ST_IDLE);
	assign item_xfer  = item_valid && item_ready;
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign pready     = 1'b1;
	assign done_fire  = (state_q == ST_DONE) && (!result_valid_q || result_ready);

	assign rd_next  = ram_rdata[ADDR_W-1:0];
	assign rd_limit = ram_rdata[RW-1:ADDR_W];

	assign add_res  = {1'b0, add_a} + {1'b0, add_b} + {{ADDR_W{1'b0}}, add_cin};
	assign fits     = !(add_res[ADDR_W-1:0] > rd_limit);
	assign nonempty = add_res[ADDR_W] && (add_res[ADDR_W-1:0] != '0);

	bpa_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_RANGES)
	) u_range_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// register read mux
	always_comb begin
		case (paddr[3])
			REG_MIN_ADDRESS: prdata = min_address_q;
			REG_USABLE_TYPE: prdata = {{(PDATA_W-TYPE_W){1'b0}}, usable_type_q};
			default:         prdata = '0;
		endcase
	end

	// next state, adder operands and table write
	always_comb begin
		state_d   = state_q;
		add_a     = '0;
		add_b     = '0;
		add_cin   = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = {rd_limit, add_res[ADDR_W-1:0]};
		case (state_q)
			ST_IDLE: begin
				if (item_xfer) begin
					case (op)
						OP_LOAD: begin
							if (entry_type == usable_type_q && entry_length != '0) begin
								state_d = ST_LD_END;
							end else begin
								state_d = ST_DONE;
							end
						end
						OP_ALLOC: state_d = ST_A_ADDR;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_LD_END: begin
				add_a = base_q;
				add_b = len_q;
				state_d = add_res[ADDR_W] ? ST_DONE : ST_LD_ALIGN;
			end
			ST_LD_ALIGN: begin
				add_a = start_q;
				add_b = PG_MASK;
				state_d = ST_LD_CHECK;
			end
			ST_LD_CHECK: begin
				add_a   = end_q;
				add_b   = ~start_q;
				add_cin = 1'b1;
				ram_waddr = count_q[AW-1:0];
				ram_wdata = {end_q, start_q};
				if (nonempty && count_q < MAX_CNT) begin
					ram_we  = 1'b1;
					state_d = ST_LD_SUM;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_LD_SUM: begin
				add_a = sum_q;
				add_b = pages_q;
				state_d = ST_DONE;
			end
			ST_A_ADDR: begin
				state_d = (idx_q >= count_q) ? ST_DONE : ST_A_CHECK;
			end
			ST_A_CHECK: begin
				add_a = rd_next;
				add_b = PG_SIZE;
				if (fits) begin
					ram_we  = 1'b1;
					state_d = ST_A_DEC;
				end else begin
					state_d = ST_A_ADDR;
				end
			end
			ST_A_DEC: begin
				add_a = sum_q;
				// a pointer bumped through zero counts every page below the limit again
				add_b = wrap_q ? (rd_limit >> PAGE_SHIFT) : '1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (done_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			min_address_q  <= MIN_ADDRESS_RST;
			usable_type_q  <= USABLE_TYPE_RST;
			count_q        <= '0;
			active_q       <= '0;
			idx_q          <= '0;
			sum_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				case (paddr[3])
					REG_MIN_ADDRESS: min_address_q <= pwdata;
					REG_USABLE_TYPE: usable_type_q <= pwdata[TYPE_W-1:0];
					default: ;
				endcase
			end
			if (done_fire) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= active_q;
					if (item_xfer && op == OP_CLEAR) begin
						count_q  <= '0;
						active_q <= '0;
						sum_q    <= '0;
					end
				end
				ST_LD_CHECK: begin
					if (nonempty && count_q < MAX_CNT) begin
						count_q <= count_q + CW'(1);
					end
				end
				ST_LD_SUM: sum_q <= add_res[ADDR_W-1:0];
				ST_A_ADDR: begin
					if (idx_q >= count_q) begin
						active_q <= count_q;
					end
				end
				ST_A_CHECK: begin
					if (fits) begin
						active_q <= idx_q;
					end else begin
						idx_q    <= idx_q + CW'(1);
						active_q <= idx_q + CW'(1);
					end
				end
				ST_A_DEC: sum_q <= add_res[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				base_q   <= entry_base;
				len_q    <= entry_length;
				page_q   <= '0;
				status_q <= (op == OP_LOAD) ? STS_SKIPPED : STS_DONE;
			end
			ST_LD_END: begin
				end_q   <= add_res[ADDR_W-1:0];
				start_q <= (base_q < min_address_q) ? min_address_q : base_q;
			end
			ST_LD_ALIGN: begin
				start_q <= add_res[ADDR_W-1:0] & ~PG_MASK;
				end_q   <= end_q & ~PG_MASK;
			end
			ST_LD_CHECK: begin
				pages_q <= add_res[ADDR_W-1:0] >> PAGE_SHIFT;
				if (!nonempty) begin
					status_q <= STS_SKIPPED;
				end else if (count_q >= MAX_CNT) begin
					status_q <= STS_FULL;
				end else begin
					status_q <= STS_DONE;
				end
			end
			ST_A_ADDR: begin
				if (idx_q >= count_q) begin
					status_q <= STS_NO_PAGE;
				end
			end
			ST_A_CHECK: begin
				if (fits) begin
					page_q   <= rd_next;
					status_q <= STS_DONE;
					wrap_q   <= add_res[ADDR_W];
				end
			end
			default: ;
		endcase
		// result register
		if (done_fire) begin
			res_page_q   <= page_q;
			res_status_q <= status_q;
			res_free_q   <= (sum_q[ADDR_W-1:FREE_W] != '0) ? '1 : sum_q[FREE_W-1:0];
			res_used_q   <= RUSED_W'(count_q);
		end
	end

	assign result_valid = result_valid_q;
	assign page_addr    = res_page_q;
	assign status       = res_status_q;
	assign free_pages   = res_free_q;
	assign ranges_used  = res_used_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("range count above table size");

	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= count_q)
		else $error("active range beyond stored ranges");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer |=> (state_q != ST_IDLE))
		else $error("sequencer idle right after item transfer");

	a_no_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == STS_NO_PAGE) |-> (page_addr == '0))
		else $error("page address nonzero with out-of-pages status");

	a_table_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_LD_CHECK || state_q == ST_A_CHECK))
		else $error("range table written outside load or alloc check");
`endif

endmodule

`default_nettype wire

// ===== tb/bump_page_allocator_top_tb.sv =====
// bump_page_allocator_top_tb: self-checking testbench for the bump page allocator
// depends on bpa_pkg and bump_page_allocator_top; the scoreboard class mirrors the range table
// directed corner items first, then random fill/drain mixes under several register settings
`timescale 1ns / 100ps

module bump_page_allocator_top_tb;
	import bpa_pkg::*;

	localparam int unsigned       RANGE_SLOTS    = MAX_RANGES_DEF;
	localparam int unsigned       PG_SHIFT       = PAGE_SHIFT_DEF;
	localparam logic [ADDR_W-1:0] PAGE_BYTES     = 64'd1 << PG_SHIFT;
	localparam logic [ADDR_W-1:0] OFFSET_MASK    = PAGE_BYTES - 64'd1;
	localparam logic [63:0]       FREE_CAP       = (64'd1 << FREE_W) - 64'd1;
	localparam logic [1:0]        OP_RESERVED    = 2'd3;
	localparam int unsigned       WATCHDOG_LIMIT = 2000;
	localparam int unsigned       ITEMS_PER_SET  = 240;
	localparam int unsigned       STRETCH_LEN    = 40;
	localparam int unsigned       MAX_REPORTS    = 50;

	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] length;
		logic [TYPE_W-1:0] etype;
	} alloc_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  page;
		logic [1:0]         status;
		logic [FREE_W-1:0]  free;
		logic [RUSED_W-1:0] used;
	} alloc_resp_t;

	typedef enum int unsigned {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

	// mirror of the range table and the queue of outcomes still owed by the block
	class allocator_scoreboard;
		logic [ADDR_W-1:0] min_addr;
		logic [TYPE_W-1:0] usable;
		logic [ADDR_W-1:0] free_ptr [RANGE_SLOTS];
		logic [ADDR_W-1:0] limit [RANGE_SLOTS];
		int unsigned       range_cnt;
		int unsigned       active;
		alloc_resp_t       outcome_q [$];
		int unsigned       errors;

		function new();
			min_addr  = MIN_ADDRESS_RST;
			usable    = USABLE_TYPE_RST;
			range_cnt = 0;
			active    = 0;
			errors    = 0;
		endfunction

		function void set_reg(input logic sel, input logic [63:0] value);
			if (sel == REG_MIN_ADDRESS) begin
				min_addr = value;
			end else begin
				usable = value[TYPE_W-1:0];
			end
		endfunction

		function int unsigned pending();
			return outcome_q.size();
		endfunction

		// clip to the minimum address, shrink to whole pages, then append
		function logic [1:0] store_entry(input logic [ADDR_W-1:0] base,
				input logic [ADDR_W-1:0] length, input logic [TYPE_W-1:0] etype);
			logic [ADDR_W-1:0] lo_addr;
			logic [ADDR_W-1:0] hi_addr;
			lo_addr = base;
			hi_addr = base + length;
			if (etype != usable || length == '0 || hi_addr <= lo_addr) begin
				return STS_SKIPPED;
			end
			if (lo_addr < min_addr) begin
				lo_addr = min_addr;
			end
			lo_addr = (lo_addr + OFFSET_MASK) & ~OFFSET_MASK;
			hi_addr = hi_addr & ~OFFSET_MASK;
			if (lo_addr >= hi_addr) begin
				return STS_SKIPPED;
			end
			if (range_cnt >= RANGE_SLOTS) begin
				return STS_FULL;
			end
			free_ptr[range_cnt] = lo_addr;
			limit[range_cnt]    = hi_addr;
			range_cnt++;
			return STS_DONE;
		endfunction

		// forward scan from the active range; the page-end test wraps at 2^64
		function logic [1:0] take_page(output logic [ADDR_W-1:0] page);
			int unsigned i;
			page = '0;
			for (i = active; i < range_cnt; i++) begin
				if (free_ptr[i] + PAGE_BYTES > limit[i]) begin
					active = i + 1;
					continue;
				end
				page        = free_ptr[i];
				free_ptr[i] = free_ptr[i] + PAGE_BYTES;
				active      = i;
				return STS_DONE;
			end
			return STS_NO_PAGE;
		endfunction

		function logic [FREE_W-1:0] free_count();
			logic [63:0] sum;
			int unsigned i;
			sum = '0;
			for (i = 0; i < range_cnt; i++) begin
				if (limit[i] > free_ptr[i]) begin
					sum += (limit[i] - free_ptr[i]) >> PG_SHIFT;
				end
			end
			if (sum > FREE_CAP) begin
				sum = FREE_CAP;
			end
			return sum[FREE_W-1:0];
		endfunction

		// called once per input transfer
		function void note_request(input alloc_req_t req);
			logic [ADDR_W-1:0] page;
			logic [1:0]        sts;
			alloc_resp_t       resp;
			page = '0;
			sts  = STS_DONE;
			case (req.op)
				OP_CLEAR: begin
					range_cnt = 0;
					active    = 0;
				end
				OP_LOAD: begin
					sts = store_entry(req.base, req.length, req.etype);
				end
				OP_ALLOC: begin
					sts = take_page(page);
				end
				default: begin
					sts = STS_DONE;
				end
			endcase
			resp.page   = page;
			resp.status = sts;
			resp.free   = free_count();
			resp.used   = range_cnt[RUSED_W-1:0];
			outcome_q.push_back(resp);
		endfunction

		function void report(input string name, input logic [63:0] want, input logic [63:0] got);
			errors++;
			// keep the log readable when everything goes wrong
			if (errors <= MAX_REPORTS) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			end
		endfunction

		// called once per result transfer
		function void check_result(input alloc_resp_t got);
			alloc_resp_t want;
			if (outcome_q.size() == 0) begin
				errors++;
				$error("result transfer with no request outstanding");
				return;
			end
			want = outcome_q.pop_front();
			if (got.page !== want.page) begin
				report("page_addr", want.page, got.page);
			end
			if (got.status !== want.status) begin
				report("status", 64'(want.status), 64'(got.status));
			end
			if (got.free !== want.free) begin
				report("free_pages", 64'(want.free), 64'(got.free));
			end
			if (got.used !== want.used) begin
				report("ranges_used", 64'(want.used), 64'(got.used));
			end
		endfunction
	endclass

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_ready;
	logic [1:0]          op           = '0;
	logic [ADDR_W-1:0]   entry_base   = '0;
	logic [ADDR_W-1:0]   entry_length = '0;
	logic [TYPE_W-1:0]   entry_type   = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic [ADDR_W-1:0]   page_addr;
	logic [1:0]          status;
	logic [FREE_W-1:0]   free_pages;
	logic [RUSED_W-1:0]  ranges_used;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [PADDR_W-1:0]  paddr        = '0;
	logic [PDATA_W-1:0]  pwdata       = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	allocator_scoreboard sb;
	logic                no_idle = 1'b0;

	bump_page_allocator_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.op           (op),
		.entry_base   (entry_base),
		.entry_length (entry_length),
		.entry_type   (entry_type),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.page_addr    (page_addr),
		.status       (status),
		.free_pages   (free_pages),
		.ranges_used  (ranges_used),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #10 clk = ~clk;

	// one register access: setup, access, then back to idle
	task automatic apb_access(input logic is_write, input logic sel,
			input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= {sel, 3'b000};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// write both registers, mirror them, read them back
	task automatic program_regs(input logic [ADDR_W-1:0] min_value,
			input logic [TYPE_W-1:0] type_value);
		logic [PDATA_W-1:0] rdata;
		apb_access(1'b1, REG_MIN_ADDRESS, min_value, rdata);
		apb_access(1'b1, REG_USABLE_TYPE, 64'(type_value), rdata);
		sb.set_reg(REG_MIN_ADDRESS, min_value);
		sb.set_reg(REG_USABLE_TYPE, 64'(type_value));
		apb_access(1'b0, REG_MIN_ADDRESS, '0, rdata);
		if (rdata !== min_value) begin
			sb.report("min_address readback", min_value, rdata);
		end
		apb_access(1'b0, REG_USABLE_TYPE, '0, rdata);
		if (rdata[TYPE_W-1:0] !== type_value) begin
			sb.report("usable_type readback", 64'(type_value), 64'(rdata[TYPE_W-1:0]));
		end
	endtask

	// drive one item after a random gap and hold it until the transfer
	task automatic send_request(input alloc_req_t req);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid   <= 1'b1;
		op           <= req.op;
		entry_base   <= req.base;
		entry_length <= req.length;
		entry_type   <= req.etype;
		do @(posedge clk); while (!item_ready);
		sb.note_request(req);
		@(negedge clk);
	endtask

	// let every owed result come back so the block is idle
	task automatic drain_results();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic alloc_req_t request_of(input logic [1:0] code,
			input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] length,
			input logic [TYPE_W-1:0] etype);
		alloc_req_t req;
		req.op     = code;
		req.base   = base;
		req.length = length;
		req.etype  = etype;
		return req;
	endfunction

	// random item; the mix decides whether the table fills up or runs dry
	function automatic alloc_req_t make_request(input mix_t mix);
		alloc_req_t  req;
		int unsigned roll;
		int unsigned clear_pct;
		int unsigned noise_pct;
		int unsigned load_pct;
		req = request_of(OP_ALLOC, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
		case (mix)
			MIX_FILL: begin
				clear_pct = 1;
				noise_pct = 3;
				load_pct  = 66;
			end
			MIX_DRAIN: begin
				clear_pct = 4;
				noise_pct = 4;
				load_pct  = 12;
			end
			default: begin
				clear_pct = 6;
				noise_pct = 4;
				load_pct  = 40;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < clear_pct) begin
			req.op = OP_CLEAR;
		end else if (roll < clear_pct + noise_pct) begin
			req.op = OP_RESERVED;
		end else if (roll < clear_pct + noise_pct + load_pct) begin
			req.op = OP_LOAD;
			roll   = $urandom_range(0, 99);
			if (roll < 75) begin
				// usable entry of a few pages around the minimum address
				req.etype = sb.usable;
				req.base  = sb.min_addr + (64'($urandom_range(0, 255)) << PG_SHIFT);
				if (roll < 15) begin
					req.base = sb.min_addr - 64'($urandom_range(0, 32'h4000));
				end
				if ($urandom_range(0, 3) == 0) begin
					req.base = req.base | ({$urandom, $urandom} & OFFSET_MASK);
				end
				req.length = 64'($urandom_range(1, 6)) << PG_SHIFT;
				if ($urandom_range(0, 1) == 0) begin
					req.length = req.length + ({$urandom, $urandom} & OFFSET_MASK);
				end
			end else if (roll < 80) begin
				req.etype  = sb.usable;
				req.length = '0;
			end else if (roll < 88) begin
				// huge or wrapping entry
				req.etype = sb.usable;
			end else if (roll < 93) begin
				req.etype  = sb.usable;
				req.length = 64'($urandom_range(1, 32'h8000));
			end
			// otherwise all fields stay random, almost always an unusable type
		end
		return req;
	endfunction

	// directed corners under the reset register values
	task automatic run_directed();
		int unsigned k;
		send_request(request_of(OP_ALLOC, '0, '0, '0));
		send_request(request_of(OP_RESERVED, '1, '1, '1));
		send_request(request_of(OP_LOAD, 64'h0010_0000, 64'h4000, 32'hFFFF_FFFF));
		send_request(request_of(OP_LOAD, '1, '0, 32'd1));
		send_request(request_of(OP_LOAD, 64'h1000, '1, 32'd1));
		send_request(request_of(OP_LOAD, 64'h0020_0001, 64'h1000, 32'd1));
		// clipped up to the minimum address, one page left
		send_request(request_of(OP_LOAD, '0, 64'h0010_1000, 32'd1));
		// range ending inside the top page; aligned down, it holds only the page below it
		send_request(request_of(OP_LOAD, 64'hFFFF_FFFF_FFFF_E000, 64'h1FFF, 32'd1));
		repeat (4) send_request(request_of(OP_ALLOC, '1, '1, '1));
		// start in the last page aligns up to zero
		send_request(request_of(OP_LOAD, 64'hFFFF_FFFF_FFFF_FF9C, 64'd50, 32'd1));
		// fill the table, the last one is dropped
		for (k = 0; k < RANGE_SLOTS - 2; k++) begin
			send_request(request_of(OP_LOAD, 64'h0100_0000 + (64'(k) << 16), 64'h3000, 32'd1));
		end
	endtask

	// result side: random stall per result, then check the transfer
	initial begin : result_sink
		int unsigned stall;
		alloc_resp_t got;
		@(negedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 11);
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
			got.page   = page_addr;
			got.status = status;
			got.free   = free_pages;
			got.used   = ranges_used;
			sb.check_result(got);
			@(negedge clk);
		end
	end

	// hang detection: too long without any transfer
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready) || psel) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$error("no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// reset, directed items, then register settings each with a random stretch
	initial begin : stimulus
		int unsigned phase;
		int unsigned n;
		mix_t        mix;
		sb  = new();
		mix = MIX_BALANCED;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		program_regs(MIN_ADDRESS_RST, USABLE_TYPE_RST);
		run_directed();
		for (phase = 0; phase < 6; phase++) begin
			drain_results();
			case (phase)
				0: program_regs('0, '0);
				1: program_regs('1, '1);
				2: program_regs(64'($urandom_range(0, 32'h0FFF_FFFF)), $urandom_range(0, 15));
				3: program_regs(MIN_ADDRESS_RST, USABLE_TYPE_RST);
				4: program_regs({$urandom, $urandom}, $urandom);
				default: program_regs(64'hFFFF_FFFF_FFF0_0000, 32'd7);
			endcase
			for (n = 0; n < ITEMS_PER_SET; n++) begin
				if (n % STRETCH_LEN == 0) begin
					mix     = mix_t'($urandom_range(0, 2));
					no_idle = ($urandom_range(0, 3) == 0);
				end
				send_request(make_request(mix));
			end
		end
		drain_results();
		repeat (40) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
